// File: sv/btmx_pkg.sv
// Shared types and constants for the binary trie max-XOR store.
// No dependencies; used by binary_trie_max_xor.
package btmx_pkg;

  localparam int FIELD_W  = 64;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // function codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: sv/btmx_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module btmx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/binary_trie_max_xor.sv
// Binary trie max-XOR store: insert, max-XOR query, clear.
// Insert and query each walk the trie one level per cycle, paced by the
// registered link RAM read.
// Clear, refused insert, empty query and unused codes: done the next cycle.
// One item at a time; done is a single-cycle strobe, the receiver cannot stall.
// Synchronous reset empties the store at once; no RAM clearing pass is needed.
// Depends on btmx_pkg and btmx_ram.
module binary_trie_max_xor #(
  parameter int KEY_BITS  = 64,
  parameter int MAX_NODES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [btmx_pkg::FUNC_W-1:0]         func,
  input  logic [btmx_pkg::FIELD_W-1:0]        key,
  output logic                                done,
  output logic [btmx_pkg::FIELD_W-1:0]        partner_key,
  output logic [btmx_pkg::FIELD_W-1:0]        best_xor,
  output logic [btmx_pkg::COUNT_W-1:0]        match_count,
  output logic [btmx_pkg::STATUS_W-1:0]       status
);

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int USED_W     = NODE_W + 1;
  localparam int DEPTH_W    = $clog2(KEY_BITS + 1);
  localparam int USED_LIMIT = MAX_NODES - 1 - KEY_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_QRY  = 4'b0100,
    S_QFIN = 4'b1000
  } state_t;

  state_t                          state, state_next;
  logic [KEY_BITS-1:0]             key_r, key_r_next;
  logic [KEY_BITS-1:0]             key_sh, key_sh_next;
  logic [KEY_BITS-1:0]             partner, partner_next;
  logic [NODE_W-1:0]               cur, cur_next;
  logic                            fresh, fresh_next;
  logic [DEPTH_W-1:0]              depth, depth_next;
  logic [USED_W-1:0]               nodes_used, nodes_used_next;
  logic [NODE_W-1:0]               root_node, root_node_next;
  logic                            done_next;
  logic [btmx_pkg::FIELD_W-1:0]    partner_key_next, best_xor_next;
  logic [btmx_pkg::COUNT_W-1:0]    match_count_next;
  logic [btmx_pkg::STATUS_W-1:0]   status_next;

  // RAM ports
  logic                            lnk_we, cnt_we;
  logic [NODE_W-1:0]               lnk_waddr, cnt_waddr, rd_addr;
  logic [2*NODE_W-1:0]             lnk_wdata, lnk_rdata;
  logic [btmx_pkg::COUNT_W-1:0]    cnt_wdata, cnt_rdata;

  // walk datapath
  logic [2*NODE_W-1:0]             links;
  logic [NODE_W-1:0]               child0, child1, child_b, child_o, new_node;
  logic [btmx_pkg::COUNT_W-1:0]    cnt_cur, cnt_inc;
  logic                            bit_b;
  logic                            full;

  // link RAM: {child for bit 1, child for bit 0}
  btmx_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_NODES)) u_links (
    .clk  (clk),
    .we   (lnk_we),
    .waddr(lnk_waddr),
    .wdata(lnk_wdata),
    .raddr(rd_addr),
    .rdata(lnk_rdata)
  );

  // count RAM: keys at or below each node
  btmx_ram #(.WIDTH(btmx_pkg::COUNT_W), .DEPTH(MAX_NODES)) u_counts (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(rd_addr),
    .rdata(cnt_rdata)
  );

  // a freshly allocated node reads as all-zero links and zero count
  assign links    = fresh ? '0 : lnk_rdata;
  assign cnt_cur  = fresh ? '0 : cnt_rdata;
  assign child0   = links[NODE_W-1:0];
  assign child1   = links[2*NODE_W-1:NODE_W];
  assign bit_b    = key_sh[KEY_BITS-1];
  assign child_b  = bit_b ? child1 : child0;
  assign child_o  = bit_b ? child0 : child1;
  assign new_node = nodes_used[NODE_W-1:0] + NODE_W'(1);
  assign cnt_inc  = (cnt_cur == btmx_pkg::COUNT_MAX) ? cnt_cur
                                                     : cnt_cur + btmx_pkg::COUNT_W'(1);
  assign full     = nodes_used > USED_W'(USED_LIMIT);
  assign busy     = (state != S_IDLE);

  // control and walk step
  always_comb begin
    state_next       = state;
    key_r_next       = key_r;
    key_sh_next      = key_sh;
    partner_next     = partner;
    cur_next         = cur;
    fresh_next       = fresh;
    depth_next       = depth;
    nodes_used_next  = nodes_used;
    root_node_next   = root_node;
    done_next        = 1'b0;
    partner_key_next = partner_key;
    best_xor_next    = best_xor;
    match_count_next = match_count;
    status_next      = status;
    lnk_we           = 1'b0;
    lnk_waddr        = cur;
    lnk_wdata        = '0;
    cnt_we           = 1'b0;
    cnt_waddr        = cur;
    cnt_wdata        = cnt_inc;
    rd_addr          = cur;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          key_r_next       = key[KEY_BITS-1:0];
          key_sh_next      = key[KEY_BITS-1:0];
          partner_next     = '0;
          depth_next       = '0;
          partner_key_next = '0;
          best_xor_next    = '0;
          match_count_next = '0;
          status_next      = btmx_pkg::ST_DONE;
          case (func)
            btmx_pkg::FN_INSERT: begin
              if (full) begin
                status_next = btmx_pkg::ST_FULL;
                done_next   = 1'b1;
              end else if (root_node == '0) begin
                root_node_next  = new_node;
                nodes_used_next = nodes_used + USED_W'(1);
                cur_next        = new_node;
                fresh_next      = 1'b1;
                state_next      = S_INS;
              end else begin
                cur_next   = root_node;
                fresh_next = 1'b0;
                rd_addr    = root_node;
                state_next = S_INS;
              end
            end
            btmx_pkg::FN_QUERY: begin
              if (root_node == '0) begin
                status_next = btmx_pkg::ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                cur_next   = root_node;
                fresh_next = 1'b0;
                rd_addr    = root_node;
                state_next = S_QRY;
              end
            end
            btmx_pkg::FN_CLEAR: begin
              nodes_used_next = '0;
              root_node_next  = '0;
              done_next       = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // insert: bump the current node, then step to (or allocate) the child, or finish at the leaf
      S_INS: begin
        cnt_we = 1'b1;
        if (depth == DEPTH_W'(KEY_BITS)) begin
          match_count_next = cnt_inc;
          done_next        = 1'b1;
          state_next       = S_IDLE;
        end else begin
          if (child_b == '0) begin
            lnk_we          = 1'b1;
            lnk_wdata       = bit_b ? {new_node, child0} : {child1, new_node};
            nodes_used_next = nodes_used + USED_W'(1);
            cur_next        = new_node;
            fresh_next      = 1'b1;
          end else begin
            cur_next   = child_b;
            fresh_next = 1'b0;
          end
          rd_addr     = cur_next;
          key_sh_next = key_sh << 1;
          depth_next  = depth + DEPTH_W'(1);
        end
      end

      // query: every allocated node has a nonzero count, so a nonzero
      // opposite link means a non-empty opposite subtree
      S_QRY: begin
        if (child_o != '0) begin
          cur_next     = child_o;
          partner_next = (partner << 1) | KEY_BITS'(!bit_b);
        end else begin
          cur_next     = child_b;
          partner_next = (partner << 1) | KEY_BITS'(bit_b);
        end
        rd_addr     = cur_next;
        key_sh_next = key_sh << 1;
        if (depth == DEPTH_W'(KEY_BITS - 1)) begin
          state_next = S_QFIN;
        end else begin
          depth_next = depth + DEPTH_W'(1);
        end
      end

      // leaf count is on the count RAM output
      S_QFIN: begin
        partner_key_next = btmx_pkg::FIELD_W'(partner);
        best_xor_next    = btmx_pkg::FIELD_W'(key_r ^ partner);
        match_count_next = cnt_rdata;
        status_next      = btmx_pkg::ST_DONE;
        done_next        = 1'b1;
        state_next       = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= '0;
      root_node  <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      root_node  <= root_node_next;
      done       <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_r_next;
    key_sh      <= key_sh_next;
    partner     <= partner_next;
    cur         <= cur_next;
    fresh       <= fresh_next;
    depth       <= depth_next;
    partner_key <= partner_key_next;
    best_xor    <= best_xor_next;
    match_count <= match_count_next;
    status      <= status_next;
  end

endmodule
